[sv/m4me_pkg.sv]
// Shared types, opcodes and permutation tables for the 4x4 matrix engine.
`default_nettype none
package m4me_pkg;

   // Operation codes carried in the request opcode field
   typedef enum logic [2:0] {
      OP_LOAD_A  = 3'd0,
      OP_LOAD_B  = 3'd1,
      OP_PRODUCT = 3'd2,
      OP_AFFINE  = 3'd3,
      OP_INVERSE = 3'd4,
      OP_DET4    = 3'd5,
      OP_DET3    = 3'd6
   } op_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_ELEM,
      S_READ,
      S_LOAD,
      S_MUL,
      S_ADD,
      S_ACC,
      S_EMIT,
      S_COPY
   } seq_state_type;

   // Final scaling of the accumulator
   typedef enum logic [1:0] {
      SH_ONE,
      SH_TWO,
      SH_THREE
   } shift_type;

   localparam int PROD_W = 128;
   localparam int ACC_W  = 136;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [3:0]         element_index;
      logic signed [31:0] element_value;
   } req_type;

   typedef struct packed {
      logic [3:0]         result_index;
      logic signed [31:0] result_value;
      logic               last;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic        en;
      logic        sel_b;
      logic [3:0]  addr;
      logic [31:0] data;
   } wr_req_type;

   typedef struct packed {
      logic       en;
      logic       sel_b;
      logic [3:0] addr;
      logic       affine;
   } rd_req_type;

   typedef struct packed {
      logic      x_load;
      logic      p_clear;
      logic      mul_en;
      logic      p_add;
      logic      x_from_p;
      logic      acc_clear;
      logic      acc_add;
      logic      neg;
      logic [1:0] limb;
      logic      limb_top;
      shift_type shift;
   } dp_ctrl_type;

   // Permutation terms of the 4x4 determinant: {odd, p0, p1, p2, p3}
   function automatic logic [8:0] det4_term(input logic [4:0] t);
      logic [8:0] r;
      case (t)
         5'd0:  r = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
         5'd1:  r = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
         5'd2:  r = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
         5'd3:  r = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
         5'd4:  r = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
         5'd5:  r = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
         5'd6:  r = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
         5'd7:  r = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
         5'd8:  r = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
         5'd9:  r = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
         5'd10: r = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
         5'd11: r = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
         5'd12: r = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
         5'd13: r = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
         5'd14: r = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
         5'd15: r = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
         5'd16: r = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
         5'd17: r = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
         5'd18: r = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
         5'd19: r = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
         5'd20: r = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
         5'd21: r = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
         5'd22: r = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
         5'd23: r = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
         default: r = '0;
      endcase
      return r;
   endfunction

   // Permutation terms of the 3x3 determinant: {odd, p0, p1, p2}
   function automatic logic [6:0] det3_term(input logic [2:0] t);
      logic [6:0] r;
      case (t)
         3'd0: r = {1'b0, 2'd0, 2'd1, 2'd2};
         3'd1: r = {1'b1, 2'd0, 2'd2, 2'd1};
         3'd2: r = {1'b1, 2'd1, 2'd0, 2'd2};
         3'd3: r = {1'b0, 2'd1, 2'd2, 2'd0};
         3'd4: r = {1'b0, 2'd2, 2'd0, 2'd1};
         3'd5: r = {1'b1, 2'd2, 2'd1, 2'd0};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[sv/m4me_store.sv]
// Element stores for matrices A and B with one registered read port.
`default_nettype none
module m4me_store #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire m4me_pkg::wr_req_type wr,
   input  wire m4me_pkg::rd_req_type rd,
   output logic [31:0]              rd_data
);
   import m4me_pkg::*;

   localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

   logic [31:0] mem_a [16];
   logic [31:0] mem_b [16];
   logic [15:0] valid_a_ff;
   logic [15:0] valid_b_ff;
   logic [31:0] rd_data_ff;

   // Track written entries; unwritten ones read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= '0;
         valid_b_ff <= '0;
      end else if (wr.en) begin
         if (wr.sel_b) valid_b_ff[wr.addr] <= 1'b1;
         else          valid_a_ff[wr.addr] <= 1'b1;
      end
   end

   // Write one element
   always_ff @(posedge clock) begin
      if (wr.en) begin
         if (wr.sel_b) mem_b[wr.addr] <= wr.data;
         else          mem_a[wr.addr] <= wr.data;
      end
   end

   // Read one element, forcing the affine column (indices 3, 7, 11 and 15) when asked
   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (rd.affine && rd.addr == 4'd15)
            rd_data_ff <= ONE;
         else if (rd.affine && rd.addr[1:0] == 2'd3)
            rd_data_ff <= '0;
         else if (rd.sel_b)
            rd_data_ff <= valid_b_ff[rd.addr] ? mem_b[rd.addr] : '0;
         else
            rd_data_ff <= valid_a_ff[rd.addr] ? mem_a[rd.addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/m4me_dp.sv]
// Shared multiply-accumulate datapath: limb multiplier, product chain, accumulator.
`default_nettype none
module m4me_dp #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire m4me_pkg::dp_ctrl_type ctrl,
   input  wire logic [31:0]          y,
   output logic [31:0]               emit_value,
   output logic                      emit_sat
);
   import m4me_pkg::*;

   logic [PROD_W-1:0]  x_ff;
   logic [PROD_W-1:0]  p_ff;
   logic signed [64:0] mul_ff;
   logic [ACC_W-1:0]   acc_ff;

   logic [31:0]        limb_bits;
   logic [32:0]        mcand;
   logic signed [64:0] prod;
   logic [PROD_W-1:0]  addend;
   logic [PROD_W-1:0]  p_sum;
   logic [ACC_W-1:0]   x_ext;
   logic [ACC_W-1:0]   term;
   logic signed [ACC_W-1:0] shifted;
   logic               fits;

   // Pick one 32-bit limb of the running product; only the top limb is signed
   assign limb_bits = x_ff[{ctrl.limb, 5'd0} +: 32];
   assign mcand     = {ctrl.limb_top & limb_bits[31], limb_bits};
   assign prod      = $signed(mcand) * $signed(y);

   // Place the registered partial product at its limb weight
   assign addend = {{(PROD_W-65){mul_ff[64]}}, mul_ff} << {ctrl.limb, 5'd0};
   assign p_sum  = p_ff + addend;

   assign x_ext = {{(ACC_W-PROD_W){x_ff[PROD_W-1]}}, x_ff};
   assign term  = ctrl.neg ? (~x_ext + 1'b1) : x_ext;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) mul_ff <= prod;
      if (ctrl.p_clear)     p_ff <= '0;
      else if (ctrl.p_add)  p_ff <= p_sum;
      if (ctrl.x_load)        x_ff <= {{(PROD_W-32){y[31]}}, y};
      else if (ctrl.x_from_p) x_ff <= p_sum;
      if (ctrl.acc_clear)    acc_ff <= '0;
      else if (ctrl.acc_add) acc_ff <= acc_ff + term;
   end

   // Scale back to the fixed-point format (floor)
   always_comb begin
      case (ctrl.shift)
         SH_ONE:   shifted = $signed(acc_ff) >>> FRAC_BITS;
         SH_TWO:   shifted = $signed(acc_ff) >>> (2 * FRAC_BITS);
         SH_THREE: shifted = $signed(acc_ff) >>> (3 * FRAC_BITS);
         default:  shifted = $signed(acc_ff) >>> FRAC_BITS;
      endcase
   end

   // Clamp to 32-bit signed
   assign fits       = (&shifted[ACC_W-1:31]) | ~(|shifted[ACC_W-1:31]);
   assign emit_sat   = ~fits;
   assign emit_value = fits ? shifted[31:0]
                     : (shifted[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

endmodule
`default_nettype wire

[sv/m4me_seq.sv]
// Sequencer: walks elements, terms, factors and limbs and registers the results.
`default_nettype none
module m4me_seq #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire m4me_pkg::req_type      req_data,
   input  wire logic [31:0]           rd_data,
   input  wire logic [31:0]           emit_value,
   input  wire logic                  emit_sat,
   output logic                       busy,
   output m4me_pkg::wr_req_type       wr,
   output m4me_pkg::rd_req_type       rd,
   output m4me_pkg::dp_ctrl_type      ctrl,
   output logic                       rsp_valid,
   output m4me_pkg::rsp_type          rsp_data
);
   import m4me_pkg::*;

   localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

   seq_state_type state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [3:0] idx_ff, idx_in;
   logic [4:0] term_ff, term_in;
   logic [1:0] fac_ff, fac_in;
   logic [1:0] limb_ff, limb_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       accept;
   logic       is_compute;
   logic [1:0] fac_last;
   logic [4:0] term_last;
   logic       elem_last;
   logic       limb_top;
   logic [8:0] d4;
   logic [6:0] d3;
   logic [1:0] col4;
   logic [1:0] col3;
   logic       term_neg;
   logic [3:0] fac_addr;
   logic       fac_sel_b;

   assign accept     = start && (state_ff == S_IDLE);
   assign is_compute = (req_data.opcode == OP_PRODUCT) || (req_data.opcode == OP_AFFINE)
                    || (req_data.opcode == OP_INVERSE) || (req_data.opcode == OP_DET4)
                    || (req_data.opcode == OP_DET3);
   assign busy      = (state_ff != S_IDLE);
   assign limb_top  = (limb_ff == fac_ff - 2'd1);
   assign elem_last = (op_ff == OP_DET4) || (op_ff == OP_DET3) || (idx_ff == 4'd15);

   assign d4 = det4_term(term_ff);
   assign d3 = det3_term(term_ff[2:0]);

   // Column of the current factor within its row of the permutation
   always_comb begin
      case (fac_ff)
         2'd0:    col4 = d4[7:6];
         2'd1:    col4 = d4[5:4];
         2'd2:    col4 = d4[3:2];
         default: col4 = d4[1:0];
      endcase
      case (fac_ff)
         2'd0:    col3 = d3[5:4];
         2'd1:    col3 = d3[3:2];
         default: col3 = d3[1:0];
      endcase
   end

   // Factor address, chain length, term count and sign per operation
   always_comb begin
      fac_sel_b = 1'b0;
      fac_addr  = '0;
      fac_last  = 2'd1;
      term_last = 5'd3;
      term_neg  = 1'b0;
      case (op_type'(op_ff))
         OP_PRODUCT, OP_AFFINE: begin
            fac_sel_b = (fac_ff == 2'd0);
            fac_addr  = (fac_ff == 2'd0) ? {idx_ff[3:2], term_ff[1:0]}
                                         : {term_ff[1:0], idx_ff[1:0]};
         end
         OP_INVERSE: begin
            term_last = 5'd2;
            term_neg  = 1'b1;
            fac_addr  = (fac_ff == 2'd0) ? {2'd3, term_ff[1:0]}
                                         : {idx_ff[1:0], term_ff[1:0]};
         end
         OP_DET4: begin
            fac_last  = 2'd3;
            term_last = 5'd23;
            term_neg  = d4[8];
            fac_addr  = {fac_ff, col4};
         end
         OP_DET3: begin
            fac_last  = 2'd2;
            term_last = 5'd5;
            term_neg  = d3[6];
            fac_addr  = {fac_ff, col3};
         end
         default: begin
            fac_addr = '0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && is_compute) state_in = S_ELEM;
         end
         S_ELEM: begin
            if (op_ff == OP_INVERSE) begin
               if (idx_ff[1:0] == 2'd3)
                  state_in = (idx_ff == 4'd15) ? S_IDLE : S_ELEM;
               else if (idx_ff[3:2] == 2'd3)
                  state_in = S_READ;
               else
                  state_in = S_COPY;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_LOAD;
         S_LOAD: state_in = (fac_ff == 2'd0) ? S_READ : S_MUL;
         S_MUL:  state_in = S_ADD;
         S_ADD: begin
            if (!limb_top)              state_in = S_MUL;
            else if (fac_ff == fac_last) state_in = S_ACC;
            else                         state_in = S_READ;
         end
         S_ACC:  state_in = (term_ff == term_last) ? S_EMIT : S_READ;
         S_EMIT: state_in = elem_last ? S_IDLE : S_ELEM;
         S_COPY: state_in = S_ELEM;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and counter updates
   always_comb begin
      op_in        = op_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      fac_in       = fac_ff;
      limb_in      = limb_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr           = '0;
      rd           = '0;
      rd.sel_b     = fac_sel_b;
      rd.addr      = fac_addr;
      rd.affine    = (op_ff == OP_AFFINE);
      ctrl         = '0;
      ctrl.limb    = limb_ff;
      ctrl.limb_top = limb_top;
      ctrl.neg     = term_neg;
      case (op_type'(op_ff))
         OP_DET4: ctrl.shift = SH_THREE;
         OP_DET3: ctrl.shift = SH_TWO;
         default: ctrl.shift = SH_ONE;
      endcase
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_data.opcode;
               idx_in = '0;
               if ((req_data.opcode == OP_LOAD_A) || (req_data.opcode == OP_LOAD_B)) begin
                  wr.en    = 1'b1;
                  wr.sel_b = (req_data.opcode == OP_LOAD_B);
                  wr.addr  = req_data.element_index;
                  wr.data  = req_data.element_value;
               end
            end
         end
         S_ELEM: begin
            term_in        = '0;
            fac_in         = '0;
            ctrl.acc_clear = 1'b1;
            if (op_ff == OP_INVERSE && idx_ff[1:0] == 2'd3) begin
               // Constant column of the affine inverse
               rsp_valid_in        = 1'b1;
               rsp_in.result_index = idx_ff;
               rsp_in.result_value = (idx_ff == 4'd15) ? ONE : '0;
               rsp_in.last         = (idx_ff == 4'd15);
               rsp_in.saturated    = 1'b0;
               idx_in              = idx_ff + 4'd1;
            end else if (op_ff == OP_INVERSE && idx_ff[3:2] != 2'd3) begin
               // Transposed rotation element
               rd.en    = 1'b1;
               rd.sel_b = 1'b0;
               rd.addr  = {idx_ff[1:0], idx_ff[3:2]};
               rd.affine = 1'b0;
            end
         end
         S_READ: begin
            rd.en = 1'b1;
         end
         S_LOAD: begin
            if (fac_ff == 2'd0) begin
               ctrl.x_load = 1'b1;
               fac_in      = 2'd1;
            end else begin
               ctrl.p_clear = 1'b1;
               limb_in      = '0;
            end
         end
         S_MUL: begin
            ctrl.mul_en = 1'b1;
         end
         S_ADD: begin
            ctrl.p_add = 1'b1;
            if (limb_top) begin
               ctrl.x_from_p = 1'b1;
               fac_in        = fac_ff + 2'd1;
            end else begin
               limb_in = limb_ff + 2'd1;
            end
         end
         S_ACC: begin
            ctrl.acc_add = 1'b1;
            term_in      = term_ff + 5'd1;
            fac_in       = '0;
         end
         S_EMIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.result_index = idx_ff;
            rsp_in.result_value = emit_value;
            rsp_in.last         = elem_last;
            rsp_in.saturated    = emit_sat;
            idx_in              = idx_ff + 4'd1;
         end
         S_COPY: begin
            rsp_valid_in        = 1'b1;
            rsp_in.result_index = idx_ff;
            rsp_in.result_value = rd_data;
            rsp_in.last         = 1'b0;
            rsp_in.saturated    = 1'b0;
            idx_in              = idx_ff + 4'd1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      idx_ff  <= idx_in;
      term_ff <= term_in;
      fac_ff  <= fac_in;
      limb_ff <= limb_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

[sv/matrix4_multiply_engine.sv]
// Top level of the 4x4 fixed-point matrix product and determinant engine.
//
// Requests enter on start/req_data and are taken at a clock edge with start
// high and busy low. Load requests (A or B) write one element in that cycle,
// give no result and leave busy low, so loads go one per cycle. Compute
// requests raise busy until their last result has left.
// Results leave on rsp_valid/rsp_data, one cycle each; the receiver cannot
// stall, and rsp_data.last marks the final result of an operation.
// All arithmetic runs through one 33x32 multiplier that builds each product
// term limb by limb, plus one wide accumulator.
// A result appears in the cycle after its value is formed.
// Synchronous reset clears both matrices to zero, drops any operation in
// flight and returns the engine to idle.
`default_nettype none
module matrix4_multiply_engine #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire m4me_pkg::req_type  req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output m4me_pkg::rsp_type      rsp_data
);
   import m4me_pkg::*;

   wr_req_type  wr;
   rd_req_type  rd;
   dp_ctrl_type ctrl;
   logic [31:0] rd_data;
   logic [31:0] emit_value;
   logic        emit_sat;

   m4me_store #(.FRAC_BITS(FRAC_BITS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   m4me_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock      (clock),
      .ctrl       (ctrl),
      .y          (rd_data),
      .emit_value (emit_value),
      .emit_sat   (emit_sat)
   );

   m4me_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .rd_data    (rd_data),
      .emit_value (emit_value),
      .emit_sat   (emit_sat),
      .busy       (busy),
      .wr         (wr),
      .rd         (rd),
      .ctrl       (ctrl),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

[bench/matrix4_multiply_engine_tb.sv]
// Self-checking testbench for the 4x4 fixed-point matrix engine.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: mirrors both matrices and queues the results each request should give
class matrix_scoreboard;
   localparam int FB = 16;
   logic signed [31:0]  mat_a [16];
   logic signed [31:0]  mat_b [16];
   m4me_pkg::rsp_type   pending_rsp [$];
   int                  mismatch_count;

   function new();
      for (int i = 0; i < 16; i++) begin
         mat_a[i] = '0;
         mat_b[i] = '0;
      end
      mismatch_count = 0;
   endfunction

   // Scale, saturate and queue one computed value
   function void push_scaled(logic [3:0] idx, logic signed [199:0] acc, int sh, logic lst);
      logic signed [199:0] v;
      m4me_pkg::rsp_type   r;
      v = acc >>> sh;
      r.result_index = idx;
      r.last = lst;
      if (v > 200'sd2147483647) begin
         r.result_value = 32'h7FFF_FFFF;
         r.saturated = 1'b1;
      end else if (v < -200'sd2147483648) begin
         r.result_value = 32'h8000_0000;
         r.saturated = 1'b1;
      end else begin
         r.result_value = v[31:0];
         r.saturated = 1'b0;
      end
      pending_rsp.push_back(r);
   endfunction

   function void push_plain(logic [3:0] idx, logic [31:0] val, logic lst);
      m4me_pkg::rsp_type r;
      r.result_index = idx;
      r.result_value = val;
      r.last = lst;
      r.saturated = 1'b0;
      pending_rsp.push_back(r);
   endfunction

   // Note an accepted request: update state, queue expected results
   function void note_request(m4me_pkg::req_type q);
      logic signed [31:0]  a [16];
      logic signed [31:0]  b [16];
      logic signed [199:0] acc, t;
      int                  p3, inv;
      case (q.opcode)
         m4me_pkg::OP_LOAD_A: mat_a[q.element_index] = q.element_value;
         m4me_pkg::OP_LOAD_B: mat_b[q.element_index] = q.element_value;
         m4me_pkg::OP_PRODUCT, m4me_pkg::OP_AFFINE: begin
            a = mat_a;
            b = mat_b;
            if (q.opcode == m4me_pkg::OP_AFFINE) begin
               a[3] = 0; a[7] = 0; a[11] = 0; a[15] = 32'sd1 << FB;
               b[3] = 0; b[7] = 0; b[11] = 0; b[15] = 32'sd1 << FB;
            end
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) begin
                  acc = '0;
                  for (int k = 0; k < 4; k++)
                     acc += 200'(b[4*r+k]) * 200'(a[4*k+c]);
                  push_scaled(4'(4*r+c), acc, FB, r == 3 && c == 3);
               end
         end
         m4me_pkg::OP_INVERSE: begin
            // Queue in index order: rotation transpose, zero column, translation, one
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) begin
                  if (r < 3 && c < 3)
                     push_plain(4'(4*r+c), mat_a[4*c+r], 1'b0);
                  else if (r < 3)
                     push_plain(4'(4*r+c), '0, 1'b0);
                  else if (c < 3) begin
                     acc = '0;
                     for (int k = 0; k < 3; k++)
                        acc += 200'(mat_a[12+k]) * 200'(mat_a[4*c+k]);
                     push_scaled(4'(4*r+c), -acc, FB, 1'b0);
                  end else
                     push_plain(4'd15, 32'sd1 << FB, 1'b1);
               end
         end
         m4me_pkg::OP_DET4: begin
            acc = '0;
            for (int p0 = 0; p0 < 4; p0++)
               for (int p1 = 0; p1 < 4; p1++)
                  for (int p2 = 0; p2 < 4; p2++) begin
                     if (p1 == p0 || p2 == p0 || p2 == p1) continue;
                     p3 = 6 - p0 - p1 - p2;
                     inv = (p0 > p1) + (p0 > p2) + (p0 > p3) + (p1 > p2) + (p1 > p3)
                           + (p2 > p3);
                     t = 200'(mat_a[p0]) * 200'(mat_a[4+p1]) * 200'(mat_a[8+p2])
                         * 200'(mat_a[12+p3]);
                     acc = inv[0] ? acc - t : acc + t;
                  end
            push_scaled(4'd0, acc, 3*FB, 1'b1);
         end
         m4me_pkg::OP_DET3: begin
            acc = '0;
            for (int p0 = 0; p0 < 3; p0++)
               for (int p1 = 0; p1 < 3; p1++) begin
                  if (p1 == p0) continue;
                  p3 = 3 - p0 - p1;
                  inv = (p0 > p1) + (p0 > p3) + (p1 > p3);
                  t = 200'(mat_a[p0]) * 200'(mat_a[4+p1]) * 200'(mat_a[8+p3]);
                  acc = inv[0] ? acc - t : acc + t;
               end
            push_scaled(4'd0, acc, 2*FB, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // Check one result against the oldest expectation
   function void check_result(m4me_pkg::rsp_type got);
      m4me_pkg::rsp_type want;
      if (pending_rsp.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: idx %0d value %h", got.result_index,
                     got.result_value);
         return;
      end
      want = pending_rsp.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: exp idx %0d val %h last %b sat %b, got idx %0d val %h last %b sat %b",
                     want.result_index, want.result_value, want.last, want.saturated,
                     got.result_index, got.result_value, got.last, got.saturated);
      end
   endfunction
endclass

module matrix4_multiply_engine_tb;
   import m4me_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   matrix_scoreboard sb = new();
   int               cycle_count = 0;
   int               leftover = 0;

   matrix4_multiply_engine uut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Sample results and watch the cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) sb.check_result(rsp_data);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Drive one request and hold it until accepted
   task automatic send_request(op_type op, logic [3:0] idx, logic [31:0] val, bit gap_ok);
      int gap;
      gap = gap_ok ? $urandom_range(0, 15) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_data.opcode = op;
      req_data.element_index = idx;
      req_data.element_value = val;
      start = 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(req_data);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain();
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_value(int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         default: return 32'($signed($urandom_range(0, 512)) - 256);
      endcase
   endfunction

   initial begin
      int mode, n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: compute on cleared stores, extremes, every op
      send_request(OP_DET4, 4'd0, 32'd0, 1'b0);
      for (int i = 0; i < 16; i++)
         send_request(OP_LOAD_A, 4'(i), (i % 5 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b0);
      send_request(OP_LOAD_B, 4'd0, 32'hFFFF_FFFF, 1'b0);
      send_request(OP_PRODUCT, 4'd0, 32'd0, 1'b0);
      send_request(OP_AFFINE, 4'd0, 32'd0, 1'b0);
      send_request(OP_INVERSE, 4'd0, 32'd0, 1'b0);
      send_request(OP_DET4, 4'd0, 32'd0, 1'b0);
      send_request(OP_DET3, 4'd0, 32'd0, 1'b0);
      send_request(op_type'(3'd7), 4'hF, 32'hFFFF_FFFF, 1'b0);
      drain();

      // Random: partial matrix loads followed by one or two compute requests
      n = 0;
      while (n < 420) begin
         mode = $urandom_range(0, 3);
         for (int i = 0; i < 16; i++) begin
            if ($urandom_range(0, 2) != 0) begin
               send_request(OP_LOAD_A, 4'(i), rand_value(mode), 1'b1);
               n++;
            end
            if ($urandom_range(0, 2) != 0) begin
               send_request(OP_LOAD_B, 4'(i), rand_value(mode), 1'b1);
               n++;
            end
         end
         if ($urandom_range(0, 15) == 0)
            send_request(op_type'(3'd7), 4'($urandom()), $urandom(), 1'b1);
         send_request(op_type'($urandom_range(2, 6)), 4'($urandom()), $urandom(), 1'b1);
         n++;
         if ($urandom_range(0, 1)) begin
            send_request(op_type'($urandom_range(2, 6)), 4'($urandom()), $urandom(), 1'b1);
            n++;
         end
         if (n > 200 && n < 240) drain();
      end

      drain();
      if (sb.mismatch_count == 0 && sb.pending_rsp.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

`default_nettype wire
